// ===== rtl/core/spt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spt_pkg;

   localparam int STATIONS  = 16;
   localparam int ST_IDX_W  = (STATIONS > 1) ? $clog2(STATIONS) : 1;
   localparam int POLY_W    = 5;
   localparam int TS_W      = 24;
   localparam int ANG_W     = 20;
   localparam int NUM_ANG   = 4;
   localparam int WIN_W     = 12;
   localparam int LIM_W     = 19;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 19;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_WINDOW     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_TOLERANCE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FOV_LIMIT       = 2'd2;

   localparam logic [WIN_W-1:0] SYNC_WINDOW_RESET     = 12'd100;
   localparam logic [LIM_W-1:0] ANGLE_TOLERANCE_RESET = 19'd6554;
   localparam logic [LIM_W-1:0] FOV_LIMIT_RESET       = 19'd98304;

   // Offsets of -2pi/3 and -4pi/3 in Q4.16, rounded to nearest.
   localparam logic signed [ANG_W:0] OFS_FIRST  = -21'sd137258;
   localparam logic signed [ANG_W:0] OFS_SECOND = -21'sd274517;

   typedef struct packed {
      logic [POLY_W-1:0]             poly;
      logic [TS_W-1:0]               sync;
      logic [TS_W-1:0]               first;
      logic [NUM_ANG-1:0][ANG_W-1:0] angle;
   } sweep_type;

   typedef struct packed {
      sweep_type sweep;
      logic      published;
   } entry_type;

   typedef struct packed {
      sweep_type sweep;
      logic      is_first;
      logic      last;
   } rsp_type;

   typedef struct packed {
      logic    v0;
      logic    v1;
      rsp_type r0;
      rsp_type r1;
   } res_pair_type;

   typedef struct packed {
      logic we;
      logic store_sweep;
      logic published;
   } store_upd_type;

   typedef struct packed {
      logic [WIN_W-1:0] sync_window;
      logic [LIM_W-1:0] angle_tolerance;
      logic [LIM_W-1:0] fov_limit;
   } cfg_type;

   function automatic logic signed [ANG_W:0] sext_ang(input logic [ANG_W-1:0] a);
      return $signed({a[ANG_W-1], a});
   endfunction

   function automatic logic [ANG_W-1:0] sat_ang(input logic signed [ANG_W:0] v);
      logic [ANG_W-1:0] r;
      if (v[ANG_W] != v[ANG_W-1]) begin
         r = v[ANG_W] ? {1'b1, {(ANG_W-1){1'b0}}} : {1'b0, {(ANG_W-1){1'b1}}};
      end else begin
         r = v[ANG_W-1:0];
      end
      return r;
   endfunction

   function automatic rsp_type make_rsp(input sweep_type s, input logic first);
      rsp_type              r;
      logic signed [ANG_W:0] ofs;
      ofs        = first ? OFS_FIRST : OFS_SECOND;
      r          = '0;
      r.sweep    = s;
      r.is_first = first;
      for (int i = 0; i < NUM_ANG; i++) begin
         r.sweep.angle[i] = sat_ang(sext_ang(s.angle[i]) + ofs);
      end
      return r;
   endfunction

   function automatic logic in_fov(input sweep_type s, input logic first,
                                   input logic [LIM_W-1:0] lim);
      logic signed [ANG_W:0] ofs;
      logic signed [ANG_W:0] a0;
      logic signed [ANG_W:0] lim_s;
      ofs   = first ? OFS_FIRST : OFS_SECOND;
      a0    = sext_ang(s.angle[0]) + ofs;
      lim_s = $signed({2'b00, lim});
      return !((a0 < -lim_s) || (a0 > lim_s));
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/spt_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spt_store (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [spt_pkg::ST_IDX_W-1:0] idx,
   input  wire spt_pkg::store_upd_type       upd,
   input  wire spt_pkg::sweep_type           wr_sweep,
   output spt_pkg::entry_type                rd_entry
);

   spt_pkg::entry_type entry_ff [spt_pkg::STATIONS];
   spt_pkg::entry_type entry_in [spt_pkg::STATIONS];

   assign rd_entry = entry_ff[idx];

   always_comb begin
      for (int s = 0; s < spt_pkg::STATIONS; s++) begin
         entry_in[s] = entry_ff[s];
      end
      if (upd.we) begin
         if (upd.store_sweep) begin
            entry_in[idx].sweep = wr_sweep;
         end
         entry_in[idx].published = upd.published;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < spt_pkg::STATIONS; s++) begin
         if (reset) begin
            entry_ff[s].sweep     <= '0;
            entry_ff[s].published <= 1'b1;
         end else begin
            entry_ff[s] <= entry_in[s];
         end
      end
   end

   // An unpublished sweep is only ever left behind by storing a new one.
   a_unpub_stores: assert property (@(posedge clock) disable iff (reset)
      upd.we && !upd.published |-> upd.store_sweep)
      else $error("station marked unpublished without storing a sweep");

endmodule

`default_nettype wire

// ===== rtl/core/spt_decide.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spt_decide (
   input  wire logic                  active,
   input  wire spt_pkg::cfg_type      cfg,
   input  wire spt_pkg::sweep_type    cur,
   input  wire spt_pkg::entry_type    stored,
   output spt_pkg::res_pair_type      pair,
   output spt_pkg::store_upd_type     upd
);

   logic [spt_pkg::TS_W-1:0]      d;
   logic [spt_pkg::TS_W-1:0]      e;
   logic [spt_pkg::WIN_W:0]       two_w;
   logic                          sync_match;
   logic signed [spt_pkg::ANG_W:0] diff;
   logic [spt_pkg::ANG_W:0]       adiff;
   logic                          ang_match;
   logic                          emit_stored;
   logic                          vis_cur_first;
   logic                          vis_cur_second;
   spt_pkg::rsp_type              rsp_stored;
   spt_pkg::rsp_type              rsp_cur_first;
   spt_pkg::rsp_type              rsp_cur_second;

   always_comb begin
      d          = cur.sync - stored.sweep.sync;
      e          = d + spt_pkg::TS_W'(cfg.sync_window);
      two_w      = {cfg.sync_window, 1'b0};
      sync_match = e < spt_pkg::TS_W'(two_w);

      diff      = spt_pkg::sext_ang(stored.sweep.angle[0]) - spt_pkg::sext_ang(cur.angle[0]);
      adiff     = diff[spt_pkg::ANG_W] ? $unsigned(-diff) : $unsigned(diff);
      ang_match = adiff < {2'b00, cfg.angle_tolerance};

      rsp_stored     = spt_pkg::make_rsp(stored.sweep, 1'b1);
      rsp_cur_first  = spt_pkg::make_rsp(cur, 1'b1);
      rsp_cur_second = spt_pkg::make_rsp(cur, 1'b0);

      emit_stored    = !stored.published
                       && spt_pkg::in_fov(stored.sweep, 1'b1, cfg.fov_limit);
      vis_cur_first  = spt_pkg::in_fov(cur, 1'b1, cfg.fov_limit);
      vis_cur_second = spt_pkg::in_fov(cur, 1'b0, cfg.fov_limit);
   end

   always_comb begin
      pair            = '0;
      upd             = '0;
      upd.we          = active;
      if (sync_match) begin
         upd.store_sweep = 1'b0;
         upd.published   = 1'b1;
         if (emit_stored) begin
            pair.v0 = 1'b1;
            pair.r0 = rsp_stored;
            pair.v1 = vis_cur_second;
            pair.r1 = rsp_cur_second;
         end else begin
            pair.v0 = vis_cur_second;
            pair.r0 = rsp_cur_second;
         end
      end else begin
         upd.store_sweep = 1'b1;
         upd.published   = ang_match;
         pair.v0         = ang_match && vis_cur_first;
         pair.r0         = rsp_cur_first;
      end
      pair.r0.last = !pair.v1;
      pair.r1.last = 1'b1;
      if (!active) begin
         pair.v0 = 1'b0;
         pair.v1 = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/spt_rsp_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spt_rsp_buf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire spt_pkg::res_pair_type pair,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output spt_pkg::rsp_type          rsp,
   output logic                      can_load
);

   logic             s0_v_ff;
   logic             s0_v_in;
   logic             s1_v_ff;
   logic             s1_v_in;
   spt_pkg::rsp_type s0_ff;
   spt_pkg::rsp_type s0_in;
   spt_pkg::rsp_type s1_ff;
   spt_pkg::rsp_type s1_in;
   logic             pop;

   assign pop       = s0_v_ff && rsp_ready;
   assign can_load  = !s0_v_ff || (pop && !s1_v_ff);
   assign rsp_valid = s0_v_ff;
   assign rsp       = s0_ff;

   always_comb begin
      s0_v_in = s0_v_ff;
      s1_v_in = s1_v_ff;
      s0_in   = s0_ff;
      s1_in   = s1_ff;
      if (pop) begin
         s0_v_in = s1_v_ff;
         s0_in   = s1_ff;
         s1_v_in = 1'b0;
      end
      if (load) begin
         s0_v_in = pair.v0;
         s0_in   = pair.r0;
         s1_v_in = pair.v1;
         s1_in   = pair.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
      end else begin
         s0_v_ff <= s0_v_in;
         s1_v_ff <= s1_v_in;
      end
      s0_ff <= s0_in;
      s1_ff <= s1_in;
   end

   // A waiting second result moves to the head once the first is taken.
   a_second_moves_up: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && rsp_ready |=> s0_v_ff && !s1_v_ff)
      else $error("second result not promoted after the first was taken");

endmodule

`default_nettype wire

// ===== rtl/core/sweep_pair_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports          Handshake        Content
// request   req_*          valid / ready    one sweep: code, timestamps, four angles
// response  rsp_*          valid / ready    one emitted sweep with offset angles
// control   csr_*          write enable     sync_window, angle_tolerance, fov_limit
//
// An item is decided while it sits in the input register; its first result is
// registered in the result buffer and presented from there. Items that give
// zero or one result flow at one per cycle while rsp_ready holds; an item with
// two results holds the next until its second is taken, the result buffer
// delivering one per cycle. Reset is synchronous and clears all station state.
// A stalled response channel holds the buffer and then the input register.

module sweep_pair_tracker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic        [spt_pkg::POLY_W-1:0]   req_poly_code,
   input  wire logic        [spt_pkg::TS_W-1:0]     req_sync_time,
   input  wire logic        [spt_pkg::TS_W-1:0]     req_first_time,
   input  wire logic signed [spt_pkg::ANG_W-1:0]    req_angle_a,
   input  wire logic signed [spt_pkg::ANG_W-1:0]    req_angle_b,
   input  wire logic signed [spt_pkg::ANG_W-1:0]    req_angle_c,
   input  wire logic signed [spt_pkg::ANG_W-1:0]    req_angle_d,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed      [spt_pkg::ANG_W-1:0]    rsp_out_angle_a,
   output logic signed      [spt_pkg::ANG_W-1:0]    rsp_out_angle_b,
   output logic signed      [spt_pkg::ANG_W-1:0]    rsp_out_angle_c,
   output logic signed      [spt_pkg::ANG_W-1:0]    rsp_out_angle_d,
   output logic             [spt_pkg::TS_W-1:0]     rsp_out_first_time,
   output logic             [spt_pkg::POLY_W-1:0]   rsp_out_poly_code,
   output logic             [spt_pkg::TS_W-1:0]     rsp_out_sync_time,
   output logic                                     rsp_is_first_sweep,
   output logic                                     rsp_last_of_run,
   input  wire logic                                csr_we,
   input  wire logic        [spt_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic        [spt_pkg::CSR_DAT_W-1:0] csr_wdata
);

   spt_pkg::cfg_type       cfg_ff;
   spt_pkg::cfg_type       cfg_in;
   logic                   in_v_ff;
   logic                   in_v_in;
   spt_pkg::sweep_type     in_ff;
   spt_pkg::sweep_type     in_in;
   spt_pkg::sweep_type     req_sweep;
   logic                   process;
   logic                   can_load;
   logic                   in_range;
   logic [spt_pkg::ST_IDX_W-1:0] idx;
   spt_pkg::entry_type     stored;
   spt_pkg::res_pair_type  pair;
   spt_pkg::store_upd_type upd;
   spt_pkg::rsp_type       rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            spt_pkg::CSR_SYNC_WINDOW: begin
               cfg_in.sync_window = csr_wdata[spt_pkg::WIN_W-1:0];
            end
            spt_pkg::CSR_ANGLE_TOLERANCE: begin
               cfg_in.angle_tolerance = csr_wdata[spt_pkg::LIM_W-1:0];
            end
            spt_pkg::CSR_FOV_LIMIT: begin
               cfg_in.fov_limit = csr_wdata[spt_pkg::LIM_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      req_sweep.poly     = req_poly_code;
      req_sweep.sync     = req_sync_time;
      req_sweep.first    = req_first_time;
      req_sweep.angle[0] = req_angle_a;
      req_sweep.angle[1] = req_angle_b;
      req_sweep.angle[2] = req_angle_c;
      req_sweep.angle[3] = req_angle_d;
   end

   assign process   = in_v_ff && can_load;
   assign req_ready = !in_v_ff || process;
   assign in_range  = int'(in_ff.poly[spt_pkg::POLY_W-1:1]) < spt_pkg::STATIONS;
   assign idx       = in_ff.poly[spt_pkg::ST_IDX_W:1];

   always_comb begin
      in_v_in = in_v_ff;
      in_in   = in_ff;
      if (process) begin
         in_v_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_v_in = 1'b1;
         in_in   = req_sweep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_window     <= spt_pkg::SYNC_WINDOW_RESET;
         cfg_ff.angle_tolerance <= spt_pkg::ANGLE_TOLERANCE_RESET;
         cfg_ff.fov_limit       <= spt_pkg::FOV_LIMIT_RESET;
         in_v_ff                <= 1'b0;
      end else begin
         cfg_ff  <= cfg_in;
         in_v_ff <= in_v_in;
      end
      in_ff <= in_in;
   end

   spt_store u_store (
      .clock    (clock),
      .reset    (reset),
      .idx      (idx),
      .upd      (upd),
      .wr_sweep (in_ff),
      .rd_entry (stored)
   );

   spt_decide u_decide (
      .active (process && in_range),
      .cfg    (cfg_ff),
      .cur    (in_ff),
      .stored (stored),
      .pair   (pair),
      .upd    (upd)
   );

   spt_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (process),
      .pair      (pair),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .can_load  (can_load)
   );

   assign rsp_out_angle_a    = $signed(rsp.sweep.angle[0]);
   assign rsp_out_angle_b    = $signed(rsp.sweep.angle[1]);
   assign rsp_out_angle_c    = $signed(rsp.sweep.angle[2]);
   assign rsp_out_angle_d    = $signed(rsp.sweep.angle[3]);
   assign rsp_out_first_time = rsp.sweep.first;
   assign rsp_out_poly_code  = rsp.sweep.poly;
   assign rsp_out_sync_time  = rsp.sweep.sync;
   assign rsp_is_first_sweep = rsp.is_first;
   assign rsp_last_of_run    = rsp.last;

   // Only a stored first sweep can be followed by another result of the same item.
   a_nonlast_is_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> rsp_is_first_sweep)
      else $error("result that is not last of its item is not a first sweep");

   // A decided item with a result shows it in the next cycle.
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      process && pair.v0 |=> rsp_valid)
      else $error("decided result not presented");

   // An item waiting for the result buffer is held unchanged.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_v_ff && !process |=> in_v_ff && $stable(in_ff))
      else $error("waiting item lost or changed");

endmodule

`default_nettype wire

// ===== test/tb_sweep_pair_tracker.sv =====
`timescale 1ns / 1ps

import spt_pkg::*;

class sweep_pair_predictor;
   int unsigned      mismatches;
   logic [WIN_W-1:0] win;
   logic [LIM_W-1:0] tol;
   logic [LIM_W-1:0] fov;
   sweep_type        held[STATIONS];
   bit               published[STATIONS];
   rsp_type          pending_sweeps[$];

   function new();
      mismatches = 0;
      win        = SYNC_WINDOW_RESET;
      tol        = ANGLE_TOLERANCE_RESET;
      fov        = FOV_LIMIT_RESET;
      for (int s = 0; s < STATIONS; s++) begin
         held[s]      = '0;
         published[s] = 1'b1;
      end
   endfunction

   function int pending();
      return pending_sweeps.size();
   endfunction

   function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
      case (idx)
         CSR_SYNC_WINDOW: begin
            win = data[WIN_W-1:0];
         end
         CSR_ANGLE_TOLERANCE: begin
            tol = data[LIM_W-1:0];
         end
         CSR_FOV_LIMIT: begin
            fov = data[LIM_W-1:0];
         end
         default: begin
         end
      endcase
   endfunction

   // Queues one emitted sweep unless its offset angle_a lies outside the field of view.
   function void emit_sweep(sweep_type s, bit first);
      rsp_type r;
      int      ofs;
      int      a0;
      int      v;
      ofs = first ? int'(OFS_FIRST) : int'(OFS_SECOND);
      a0  = int'($signed(s.angle[0])) + ofs;
      if (a0 < -int'(fov) || a0 > int'(fov)) begin
         return;
      end
      r.sweep = s;
      for (int i = 0; i < NUM_ANG; i++) begin
         v = int'($signed(s.angle[i])) + ofs;
         if (v > 524287) begin
            v = 524287;
         end
         if (v < -524288) begin
            v = -524288;
         end
         r.sweep.angle[i] = v[ANG_W-1:0];
      end
      r.is_first = first;
      r.last     = 1'b0;
      pending_sweeps.push_back(r);
   endfunction

   function void note_input(sweep_type s);
      int          st;
      int          before_cnt;
      int          diff;
      logic [23:0] d;
      logic [23:0] dw;
      st = int'(s.poly >> 1);
      if (st >= STATIONS) begin
         return;
      end
      before_cnt = pending_sweeps.size();
      d  = s.sync - held[st].sync;
      dw = d + 24'(win);
      if (int'(dw) < 2 * int'(win)) begin
         if (!published[st]) begin
            emit_sweep(held[st], 1'b1);
            published[st] = 1'b1;
         end
         emit_sweep(s, 1'b0);
      end else begin
         diff = int'($signed(held[st].angle[0])) - int'($signed(s.angle[0]));
         if (diff < 0) begin
            diff = -diff;
         end
         if (diff < int'(tol)) begin
            emit_sweep(s, 1'b1);
            published[st] = 1'b1;
         end else begin
            published[st] = 1'b0;
         end
         held[st] = s;
      end
      if (pending_sweeps.size() > before_cnt) begin
         pending_sweeps[pending_sweeps.size() - 1].last = 1'b1;
      end
   endfunction

   task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task compare(string name, logic [23:0] got, logic [23:0] want);
      if (got !== want) begin
         report($sformatf("%s got %h expected %h", name, got, want));
      end
   endtask

   task check_result(rsp_type got);
      rsp_type want;
      if (pending_sweeps.size() == 0) begin
         report("result arrived with no item outstanding");
         return;
      end
      want = pending_sweeps.pop_front();
      for (int i = 0; i < NUM_ANG; i++) begin
         compare($sformatf("angle %0d", i), 24'(got.sweep.angle[i]), 24'(want.sweep.angle[i]));
      end
      compare("first_time", got.sweep.first, want.sweep.first);
      compare("poly_code", 24'(got.sweep.poly), 24'(want.sweep.poly));
      compare("sync_time", got.sweep.sync, want.sweep.sync);
      compare("is_first_sweep", 24'(got.is_first), 24'(want.is_first));
      compare("last_of_run", 24'(got.last), 24'(want.last));
   endtask
endclass

module tb_sweep_pair_tracker;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [POLY_W-1:0]           req_poly_code = '0;
   logic [TS_W-1:0]             req_sync_time = '0;
   logic [TS_W-1:0]             req_first_time = '0;
   logic signed [ANG_W-1:0]     req_angle_a = '0;
   logic signed [ANG_W-1:0]     req_angle_b = '0;
   logic signed [ANG_W-1:0]     req_angle_c = '0;
   logic signed [ANG_W-1:0]     req_angle_d = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [ANG_W-1:0]     rsp_out_angle_a;
   logic signed [ANG_W-1:0]     rsp_out_angle_b;
   logic signed [ANG_W-1:0]     rsp_out_angle_c;
   logic signed [ANG_W-1:0]     rsp_out_angle_d;
   logic [TS_W-1:0]             rsp_out_first_time;
   logic [POLY_W-1:0]           rsp_out_poly_code;
   logic [TS_W-1:0]             rsp_out_sync_time;
   logic                        rsp_is_first_sweep;
   logic                        rsp_last_of_run;
   logic                        csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_DAT_W-1:0]        csr_wdata = '0;

   sweep_pair_predictor tracker_model = new();
   bit                  no_idle = 1'b0;
   int unsigned         ready_hold = 0;
   int unsigned         stall_len;

   sweep_pair_tracker u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_poly_code      (req_poly_code),
      .req_sync_time      (req_sync_time),
      .req_first_time     (req_first_time),
      .req_angle_a        (req_angle_a),
      .req_angle_b        (req_angle_b),
      .req_angle_c        (req_angle_c),
      .req_angle_d        (req_angle_d),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_angle_a    (rsp_out_angle_a),
      .rsp_out_angle_b    (rsp_out_angle_b),
      .rsp_out_angle_c    (rsp_out_angle_c),
      .rsp_out_angle_d    (rsp_out_angle_d),
      .rsp_out_first_time (rsp_out_first_time),
      .rsp_out_poly_code  (rsp_out_poly_code),
      .rsp_out_sync_time  (rsp_out_sync_time),
      .rsp_is_first_sweep (rsp_is_first_sweep),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 40);
   endfunction

   always @(posedge clock) begin
      if (no_idle) begin
         rsp_ready  <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_ready) begin
         stall_len = idle_length();
         if (stall_len != 0) begin
            rsp_ready  <= 1'b0;
            ready_hold <= stall_len - 1;
         end else begin
            ready_hold <= $urandom_range(0, 12);
         end
      end else begin
         rsp_ready  <= 1'b1;
         ready_hold <= $urandom_range(0, 12);
      end
   end

   always @(posedge clock) begin : watch_results
      rsp_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.sweep.angle[0] = rsp_out_angle_a;
         seen.sweep.angle[1] = rsp_out_angle_b;
         seen.sweep.angle[2] = rsp_out_angle_c;
         seen.sweep.angle[3] = rsp_out_angle_d;
         seen.sweep.first    = rsp_out_first_time;
         seen.sweep.poly     = rsp_out_poly_code;
         seen.sweep.sync     = rsp_out_sync_time;
         seen.is_first       = rsp_is_first_sweep;
         seen.last           = rsp_last_of_run;
         tracker_model.check_result(seen);
      end
   end

   task automatic send_sweep(input sweep_type s);
      int unsigned gap;
      gap = no_idle ? 0 : idle_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_poly_code  <= s.poly;
      req_sync_time  <= s.sync;
      req_first_time <= s.first;
      req_angle_a    <= s.angle[0];
      req_angle_b    <= s.angle[1];
      req_angle_c    <= s.angle[2];
      req_angle_d    <= s.angle[3];
      do @(posedge clock); while (!req_ready);
      tracker_model.note_input(s);
   endtask

   task automatic send_fields(input int poly, input int sync, input int first,
                              input int a, input int b, input int c, input int d);
      sweep_type s;
      s.poly     = POLY_W'(poly);
      s.sync     = TS_W'(sync);
      s.first    = TS_W'(first);
      s.angle[0] = ANG_W'(a);
      s.angle[1] = ANG_W'(b);
      s.angle[2] = ANG_W'(c);
      s.angle[3] = ANG_W'(d);
      send_sweep(s);
   endtask

   // Zero-result items may still be inside the block, so the task keeps clocking after the drain.
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker_model.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic load_settings(input int win, input int tol, input int fov);
      logic [CSR_IDX_W-1:0] idx[3];
      logic [CSR_DAT_W-1:0] val[3];
      idx = '{CSR_SYNC_WINDOW, CSR_ANGLE_TOLERANCE, CSR_FOV_LIMIT};
      val = '{CSR_DAT_W'(win), CSR_DAT_W'(tol), CSR_DAT_W'(fov)};
      csr_we <= 1'b1;
      for (int i = 0; i < 3; i++) begin
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         tracker_model.set_reg(idx[i], val[i]);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [ANG_W-1:0] clamp_angle(input int v);
      if (v > 524287) begin
         v = 524287;
      end
      if (v < -524288) begin
         v = -524288;
      end
      return v[ANG_W-1:0];
   endfunction

   function automatic logic [ANG_W-1:0] pick_angle();
      int v;
      case ($urandom_range(0, 5))
         0, 1: begin
            v = int'($urandom());
         end
         5: begin
            v = $urandom_range(0, 1) ? -524288 : 524287;
         end
         default: begin
            v = int'($urandom_range(0, 440000)) - 40000;
         end
      endcase
      return v[ANG_W-1:0];
   endfunction

   // Most items land in or just beside a station's sync window or close to its stored
   // angle, so that pairing and re-anchoring are exercised far more than chance would.
   function automatic sweep_type random_sweep();
      sweep_type   s;
      int          st;
      int          w;
      int          t;
      int          delta;
      logic [23:0] base;
      st = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
      s.poly  = {4'(st), 1'($urandom_range(0, 1))};
      s.first = TS_W'($urandom());
      for (int i = 0; i < NUM_ANG; i++) begin
         s.angle[i] = pick_angle();
      end
      w    = int'(tracker_model.win);
      t    = int'(tracker_model.tol);
      base = tracker_model.held[st].sync;
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6, 7: begin
            case ($urandom_range(0, 7))
               0: delta = -w;
               1: delta = w - 1;
               2: delta = -w - 1;
               3: delta = w;
               default: delta = int'($urandom_range(0, 2 * w - 1)) - w;
            endcase
            s.sync = base + TS_W'(delta);
         end
         8, 9, 10, 11: begin
            case ($urandom_range(0, 5))
               0: delta = t;
               1: delta = -t;
               2: delta = t - 1;
               3: delta = 1 - t;
               default: delta = int'($urandom_range(0, 2 * t)) - t;
            endcase
            s.sync     = TS_W'($urandom());
            s.angle[0] = clamp_angle(int'($signed(tracker_model.held[st].angle[0])) + delta);
         end
         default: begin
            s.sync = TS_W'($urandom());
         end
      endcase
      return s;
   endfunction

   task automatic run_phase(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) begin
            no_idle = ($urandom_range(0, 3) == 0);
         end
         send_sweep(random_sweep());
      end
      no_idle = 1'b0;
      settle();
   endtask

   initial begin
      int phase_win[8];
      int phase_tol[8];
      int phase_fov[8];
      phase_win = '{100, 1, 4095, 4095, 1, 0, 0, 0};
      phase_tol = '{6554, 0, 524287, 0, 524287, 0, 0, 0};
      phase_fov = '{98304, 0, 524287, 524287, 98304, 0, 0, 0};
      for (int p = 5; p < 8; p++) begin
         phase_win[p] = $urandom_range(1, 4095);
         phase_tol[p] = $urandom_range(0, 524287);
         phase_fov[p] = $urandom_range(0, 524287);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_fields(0, 50, 0, 274517, -524288, 524287, 0);
      send_fields(2, 'h800000, 'hFFFFFF, 200000, 1, -1, 12345);
      send_fields(3, 'h800063, 'h123456, 274517, -300000, 300000, -1);
      send_fields(2, 'h7FFF9C, 'h000001, 372821, 0, 0, 0);
      send_fields(2, 'h800064, 'hABCDEF, 206553, 524287, -524288, 100);
      send_fields(3, 'h7FFFFF, 'h555555, 213107, 7, 8, 9);
      send_fields(3, 'h800000, 'hAAAAAA, 176213, -1, -2, -3);
      send_fields(6, 5, 'h000100, 372822, 0, 0, 0);
      send_fields(7, 'hFFFFFF, 'h000200, 176212, 0, 0, 0);
      send_fields(6, 99, 'h000300, 300000, -400000, 400000, 0);
      send_fields(6, 100, 'h000400, 6553, 0, 0, 0);
      send_fields(8, 'h400000, 'h010203, -300000, 1000, 2000, 3000);
      send_fields(9, 'h400010, 'h040506, 274517, -1000, -2000, -3000);
      send_fields(8, 'h400020, 'h070809, 250000, 0, 0, 0);
      send_fields(4, 'hFFFFF0, 'hFEDCBA, 150000, 11, 22, 33);
      send_fields(5, 'h000010, 0, 274517, -44, -55, -66);
      send_fields(31, 'hFFFFFF, 'hFFFFFF, -524288, 524287, -524288, 524287);
      send_fields(30, 'h7FFFFF, 0, 524287, -524288, 524287, -524288);
      send_fields(30, 'h800000, 'h0F0F0F, 524287, -524288, 0, 0);
      send_fields(1, 0, 0, 0, 0, 0, 0);
      settle();

      for (int p = 0; p < 8; p++) begin
         load_settings(phase_win[p], phase_tol[p], phase_fov[p]);
         run_phase(p == 1 ? 100 : 185);
      end

      repeat (20) @(posedge clock);
      if (tracker_model.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
